@@ design/assert_macros.svh @@
// Assertion macros used by the top level of the three-axis scalar Kalman filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define TSK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define TSK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tsk_pkg.sv @@
// Package with types, constants and the microcode table of the Kalman filter.
package tsk_pkg;

  // Field and state widths.
  localparam int SAMPLE_W  = 17;
  localparam int EST_W     = 33;
  localparam int DIFF_W    = 34;
  localparam int VAR_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int AXIS_W    = 2;
  localparam int PC_W      = 3;

  // Default fraction width and the reset noise values in whole units.
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NOISE_XY_UNITS = 100;
  localparam int NOISE_Z_UNITS  = 400;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Q   = 2'd0,
    CFG_RXY = 2'd1,
    CFG_RZ  = 2'd2
  } cfg_idx_e;

  // Datapath operations, one per microcode step.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PRED,
    OP_DEN,
    OP_DIV0,
    OP_DIVS,
    OP_MUL,
    OP_UPD,
    OP_OUT
  } op_e;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    JC_NONE,
    JC_NO_INPUT,
    JC_CNT_NZ,
    JC_AXIS_MORE,
    JC_OUT_BUSY
  } jc_e;

  typedef logic [PC_W-1:0] pc_t;

  // One control word of the program.
  typedef struct packed {
    op_e op;
    jc_e jc;
    pc_t target;
  } ucode_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic cnt_nz;
    logic axis_more;
    logic out_busy;
  } tsk_stat_t;

  // Step names of the program.
  localparam pc_t PC_IDLE = 3'd0;
  localparam pc_t PC_PRED = 3'd1;
  localparam pc_t PC_DEN  = 3'd2;
  localparam pc_t PC_DIV0 = 3'd3;
  localparam pc_t PC_DIVS = 3'd4;
  localparam pc_t PC_MUL  = 3'd5;
  localparam pc_t PC_UPD  = 3'd6;
  localparam pc_t PC_OUT  = 3'd7;

  // The filter program: a taken jump goes to target, else to the next step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE: w = '{op: OP_IDLE, jc: JC_NO_INPUT,  target: PC_IDLE};
      PC_PRED: w = '{op: OP_PRED, jc: JC_NONE,      target: PC_IDLE};
      PC_DEN:  w = '{op: OP_DEN,  jc: JC_NONE,      target: PC_IDLE};
      PC_DIV0: w = '{op: OP_DIV0, jc: JC_NONE,      target: PC_IDLE};
      PC_DIVS: w = '{op: OP_DIVS, jc: JC_CNT_NZ,    target: PC_DIVS};
      PC_MUL:  w = '{op: OP_MUL,  jc: JC_NONE,      target: PC_IDLE};
      PC_UPD:  w = '{op: OP_UPD,  jc: JC_AXIS_MORE, target: PC_PRED};
      PC_OUT:  w = '{op: OP_OUT,  jc: JC_OUT_BUSY,  target: PC_OUT};
      default: w = '{op: OP_IDLE, jc: JC_NONE,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/tsk_if.sv @@
// Valid/ready channel interfaces for samples and filtered estimates.
interface tsk_in_if import tsk_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface tsk_out_if import tsk_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] est_x;
  logic signed [EST_W-1:0] est_y;
  logic signed [EST_W-1:0] est_z;

  modport source (output valid, est_x, est_y, est_z, input ready);
  modport sink (input valid, est_x, est_y, est_z, output ready);
endinterface

@@ design/tsk_useq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
module tsk_useq import tsk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tsk_stat_t stat_i,
  output op_e       op_o
);

  pc_t    pc_q, pc_d;
  ucode_t uw;
  logic   take;

  // Fetch the control word of the current step.
  assign uw   = ucode_rom(pc_q);
  assign op_o = uw.op;

  // Evaluate the jump condition and pick the next step.
  always_comb begin
    unique case (uw.jc)
      JC_NONE:      take = 1'b0;
      JC_NO_INPUT:  take = !stat_i.in_valid;
      JC_CNT_NZ:    take = stat_i.cnt_nz;
      JC_AXIS_MORE: take = stat_i.axis_more;
      JC_OUT_BUSY:  take = stat_i.out_busy;
      default:      take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + pc_t'(1);
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ design/tsk_dpath.sv @@
// Filter datapath: per-axis state, restoring divider, multipliers, output register.
module tsk_dpath import tsk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_e              op_i,
  input  logic [CFG_W-1:0] q_i,
  input  logic [CFG_W-1:0] rxy_i,
  input  logic [CFG_W-1:0] rz_i,
  output tsk_stat_t        stat_o,
  tsk_in_if.sink           sample_s,
  tsk_out_if.source        result_m
);

  localparam int GW    = FRAC_BITS + 1;
  localparam int CW    = $clog2(FRAC_BITS);
  localparam int DEN_W = VAR_W + 1;
  localparam int REM_W = VAR_W + 2;
  localparam int SW    = (SAMPLE_W + FRAC_BITS > EST_W) ? SAMPLE_W + FRAC_BITS : EST_W + 1;
  localparam int PEW   = GW + 1 + DIFF_W;
  localparam int PVW   = GW + VAR_W;
  localparam int SUM_W = DIFF_W + 1;
  localparam logic [GW-1:0] ONE = GW'(1) << FRAC_BITS;
  localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

  // Captured samples and per-axis filter state.
  logic signed [SAMPLE_W-1:0] smp_q [3];
  logic signed [EST_W-1:0]    est_q [3];
  logic [VAR_W-1:0]           var_q [3];
  logic [AXIS_W-1:0]          axis_q;

  // Working registers of one axis update.
  logic [VAR_W-1:0]        pred_q;
  logic [DEN_W-1:0]        den_q;
  logic [REM_W-1:0]        rem_q;
  logic [GW-1:0]           gain_q;
  logic [CW-1:0]           cnt_q;
  logic signed [EST_W-1:0] scaled_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PEW-1:0]   pe_q;
  logic [PVW-1:0]          pv_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [EST_W-1:0] out_x_q, out_y_q, out_z_q;

  logic                       in_acc, axis_last, out_busy, out_load;
  logic signed [SAMPLE_W-1:0] smp_sel;
  logic signed [EST_W-1:0]    est_sel;
  logic [CFG_W-1:0]           r_sel;
  logic [VAR_W:0]             pred_sum;
  logic [VAR_W-1:0]           pred_sat;
  logic signed [SW-1:0]       sc_ext;
  logic signed [EST_W-1:0]    scaled_d;
  logic [REM_W-1:0]           div_sh, div_rem, den_ext;
  logic                       div_ge;
  logic signed [PEW-1:0]      pe_shr;
  logic signed [SUM_W-1:0]    est_sum;
  logic signed [EST_W-1:0]    est_new;

  // Handshake and status.
  assign sample_s.ready = (op_i == OP_IDLE);
  assign in_acc         = sample_s.valid && sample_s.ready;
  assign axis_last      = (axis_q == AXIS_W'(2));
  assign out_busy       = out_valid_q && !result_m.ready;
  assign out_load       = (op_i == OP_OUT) && !out_busy;

  assign stat_o = '{in_valid: sample_s.valid, cnt_nz: (cnt_q != '0),
                    axis_more: !axis_last, out_busy: out_busy};

  // Operand selection for the current axis.
  assign smp_sel = smp_q[axis_q];
  assign est_sel = est_q[axis_q];
  assign r_sel   = axis_last ? rz_i : rxy_i;

  // Predicted variance, saturated to 32 bits.
  assign pred_sum = {1'b0, var_q[axis_q]} + {1'b0, q_i};
  assign pred_sat = pred_sum[VAR_W] ? '1 : pred_sum[VAR_W-1:0];

  // Scaled sample, saturated to the estimate range.
  always_comb begin
    sc_ext = SW'(smp_sel) <<< FRAC_BITS;
    if ((&sc_ext[SW-1:EST_W-1]) || !(|sc_ext[SW-1:EST_W-1])) begin
      scaled_d = sc_ext[EST_W-1:0];
    end else begin
      scaled_d = sc_ext[SW-1] ? EST_MIN : EST_MAX;
    end
  end

  // One restoring division step; a zero denominator yields zero quotient bits.
  assign den_ext = REM_W'(den_q);
  assign div_sh  = (op_i == OP_DIVS) ? {rem_q[REM_W-2:0], 1'b0} : rem_q;
  assign div_ge  = (den_q != '0) && (div_sh >= den_ext);
  assign div_rem = div_ge ? div_sh - den_ext : div_sh;

  // Estimate update: floor shift of the product, then clamp.
  always_comb begin
    pe_shr  = pe_q >>> FRAC_BITS;
    est_sum = SUM_W'(est_sel) + SUM_W'($signed(pe_shr[DIFF_W-1:0]));
    if ((&est_sum[SUM_W-1:EST_W-1]) || !(|est_sum[SUM_W-1:EST_W-1])) begin
      est_new = est_sum[EST_W-1:0];
    end else begin
      est_new = est_sum[SUM_W-1] ? EST_MIN : EST_MAX;
    end
  end

  // Sample capture and working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= sample_s.sample_x;
      smp_q[1] <= sample_s.sample_y;
      smp_q[2] <= sample_s.sample_z;
    end
    case (op_i)
      OP_PRED: begin
        pred_q   <= pred_sat;
        scaled_q <= scaled_d;
        gain_q   <= '0;
      end
      OP_DEN: begin
        den_q  <= DEN_W'(pred_q) + DEN_W'(r_sel);
        rem_q  <= REM_W'(pred_q);
        diff_q <= DIFF_W'(scaled_q) - DIFF_W'(est_sel);
        cnt_q  <= CW'(FRAC_BITS - 1);
      end
      OP_DIV0: begin
        rem_q  <= div_rem;
        gain_q <= {gain_q[GW-2:0], div_ge};
      end
      OP_DIVS: begin
        rem_q  <= div_rem;
        gain_q <= {gain_q[GW-2:0], div_ge};
        cnt_q  <= cnt_q - CW'(1);
      end
      OP_MUL: begin
        pe_q <= $signed({1'b0, gain_q}) * diff_q;
        pv_q <= (ONE - gain_q) * pred_q;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_q <= est_q[0];
      out_y_q <= est_q[1];
      out_z_q <= est_q[2];
    end
  end

  // Filter state, axis counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= '0;
        var_q[i] <= '0;
      end
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_UPD) begin
        est_q[axis_q] <= est_new;
        var_q[axis_q] <= pv_q[FRAC_BITS+VAR_W-1:FRAC_BITS];
        axis_q        <= axis_last ? '0 : axis_q + AXIS_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_m.valid = out_valid_q;
  assign result_m.est_x = out_x_q;
  assign result_m.est_y = out_y_q;
  assign result_m.est_z = out_z_q;

endmodule

@@ design/three_axis_scalar_kalman.sv @@
// Top level of the three-axis scalar Kalman filter.
//
// Usage: samples arrive on sample_s (valid/ready), one signed integer per
// axis; filtered estimates leave on result_m with 16 fraction bits by default.
// An item is taken when valid and ready are both high at a rising clock edge.
// Three noise registers (q, r for x and y, r for z) are written through the
// cfg_* port; the user must write them only while the block is idle, as the
// block itself does not enforce it. An index beyond the list is ignored.
// A small microcode program runs each axis in turn: predict, denominator,
// a restoring division of FRAC_BITS + 1 quotient steps, two multiplies and the
// state update. An item is taken only while the program is idle, so a new item
// is not taken before the last one has passed its output step.
// Reset clears estimates and variances and loads the default noise values.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the following result at its final step.
`include "assert_macros.svh"

module three_axis_scalar_kalman import tsk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tsk_in_if.sink               sample_s,
  tsk_out_if.source            result_m
);

  // Reset values of the noise registers, saturated to 32 bits.
  localparam logic [63:0] Q_WIDE  = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] XY_WIDE = 64'(NOISE_XY_UNITS) << FRAC_BITS;
  localparam logic [63:0] Z_WIDE  = 64'(NOISE_Z_UNITS) << FRAC_BITS;
  localparam logic [CFG_W-1:0] Q_RST  = (Q_WIDE > 64'hFFFF_FFFF) ? '1 : Q_WIDE[CFG_W-1:0];
  localparam logic [CFG_W-1:0] XY_RST = (XY_WIDE > 64'hFFFF_FFFF) ? '1 : XY_WIDE[CFG_W-1:0];
  localparam logic [CFG_W-1:0] Z_RST  = (Z_WIDE > 64'hFFFF_FFFF) ? '1 : Z_WIDE[CFG_W-1:0];

  logic [CFG_W-1:0] q_q, rxy_q, rz_q;
  op_e              op;
  tsk_stat_t        stat;

  // Noise registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q   <= Q_RST;
      rxy_q <= XY_RST;
      rz_q  <= Z_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_Q)   q_q   <= cfg_data_i;
      if (cfg_idx_i == CFG_RXY) rxy_q <= cfg_data_i;
      if (cfg_idx_i == CFG_RZ)  rz_q  <= cfg_data_i;
    end
  end

  // Program sequencer.
  tsk_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  // Datapath.
  tsk_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .q_i      (q_q),
    .rxy_i    (rxy_q),
    .rz_i     (rz_q),
    .stat_o   (stat),
    .sample_s (sample_s),
    .result_m (result_m)
  );

  // A taken item always starts the prediction step next.
  `TSK_ASSERT_NXT(a_accept_starts, sample_s.valid && sample_s.ready, op == OP_PRED, "item taken but program did not start")
  // A new result appears only after the output step.
  `TSK_ASSERT_IMP(a_result_from_out, $rose(result_m.valid), $past(op == OP_OUT), "result valid without output step")
  // A taken result with nothing new to load leaves the output empty.
  `TSK_ASSERT_NXT(a_taken_clears, result_m.valid && result_m.ready && op != OP_OUT, !result_m.valid, "result repeated after it was taken")

endmodule

@@ bench/three_axis_scalar_kalman_test.sv @@
`timescale 1ns / 1ps
// Testbench of the three-axis scalar Kalman filter: directed and random samples checked against a predictor.
module three_axis_scalar_kalman_test;
  import tsk_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  // This index has no register behind it, so writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [CFG_W-1:0] NOISE_MAX = 32'hFFFF_FFFF;
  localparam int MAX_WAIT = 13;
  localparam int LATENCY = 3 * (FRAC + 5) + 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1330;
  localparam longint EST_HI = 64'sd4294967295;
  localparam longint EST_LO = -64'sd4294967296;
  localparam int SAMPLE_HI = 65535;
  localparam int SAMPLE_LO = -65536;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [EST_W-1:0] est_t;
  typedef struct packed {
    est_t x;
    est_t y;
    est_t z;
  } est_set_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  tsk_in_if sample_if ();
  tsk_out_if result_if ();

  three_axis_scalar_kalman DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_s   (sample_if),
    .result_m   (result_if)
  );

  // Predictor copy of the noise registers and the per-axis filter state.
  logic [CFG_W-1:0] q_now;
  logic [CFG_W-1:0] rxy_now;
  logic [CFG_W-1:0] rz_now;
  longint estimate_now [3];
  logic [VAR_W-1:0] variance_now [3];

  est_set_t estimates_due [$];
  bit failed;
  bit steady;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_est(longint v);
    if (v > EST_HI) return EST_HI;
    if (v < EST_LO) return EST_LO;
    return v;
  endfunction

  // One filter update of one axis; advances the predicted state.
  function automatic est_t kalman_axis(int axis, sample_t s, logic [CFG_W-1:0] r);
    longint unsigned unity;
    longint unsigned pred;
    longint unsigned den;
    longint unsigned gain;
    longint scaled;
    longint diff;
    longint step;
    unity = 64'd1 << FRAC;
    pred = 64'(variance_now[axis]) + 64'(q_now);
    if (pred > 64'hFFFF_FFFF) pred = 64'hFFFF_FFFF;
    den = pred + 64'(r);
    // A zero denominator leaves the axis untouched.
    gain = (den == 0) ? 64'd0 : (pred << FRAC) / den;
    if (gain > unity) gain = unity;
    scaled = clamp_est(longint'(s) * longint'(unity));
    diff = scaled - estimate_now[axis];
    // Arithmetic shift rounds toward minus infinity.
    step = (longint'(gain) * diff) >>> FRAC;
    estimate_now[axis] = clamp_est(estimate_now[axis] + step);
    variance_now[axis] = VAR_W'(((unity - gain) * pred) >> FRAC);
    return est_t'(estimate_now[axis]);
  endfunction

  function automatic void check_field(string name, est_t want, est_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Sends one item; entered and left at a falling edge.
  task automatic send_sample(sample_t x, sample_t y, sample_t z);
    int gap;
    est_set_t want;
    gap = steady ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap > 0) begin
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.sample_x = x;
    sample_if.sample_y = y;
    sample_if.sample_z = z;
    sample_if.valid = 1'b1;
    do @(posedge clk_i); while (!sample_if.ready);
    want.x = kalman_axis(0, x, rxy_now);
    want.y = kalman_axis(1, y, rxy_now);
    want.z = kalman_axis(2, z, rz_now);
    estimates_due.push_back(want);
    @(negedge clk_i);
    sample_if.valid = 1'b0;
  endtask

  // Holds off until every expected estimate has come and the block is idle.
  task automatic settle_idle();
    while (estimates_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_noise(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_idx_i = idx;
    cfg_data_i = value;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_Q:   q_now = value;
      CFG_RXY: rxy_now = value;
      CFG_RZ:  rz_now = value;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] draw_noise();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return NOISE_MAX;
      2: return $urandom_range(32'h0004_0000, 0);
      3: return $urandom_range(32'h0100_0000, 0);
      default: return $urandom;
    endcase
  endfunction

  // Noisy readings around a level and full-range values in equal share, with extremes mixed in.
  function automatic sample_t draw_sample(int level);
    int v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return sample_t'($urandom);
      8: return sample_t'(SAMPLE_HI);
      9: return sample_t'(SAMPLE_LO);
      default: begin
        v = level + int'($urandom_range(400, 0)) - 200;
        if (v > SAMPLE_HI) v = SAMPLE_HI;
        if (v < SAMPLE_LO) v = SAMPLE_LO;
        return sample_t'(v);
      end
    endcase
  endfunction

  // Extremes and bit patterns with the reset noise values.
  task automatic test_extremes();
    steady = 1'b1;
    send_sample('0, '0, '0);
    send_sample(sample_t'(SAMPLE_HI), sample_t'(SAMPLE_HI), sample_t'(SAMPLE_HI));
    send_sample(sample_t'(SAMPLE_LO), sample_t'(SAMPLE_LO), sample_t'(SAMPLE_LO));
    steady = 1'b0;
    send_sample(sample_t'(SAMPLE_HI), sample_t'(SAMPLE_LO), '0);
    send_sample(sample_t'(-1), sample_t'(1), sample_t'(-1));
    send_sample(17'h0AAAA, 17'h15555, 17'h0AAAA);
    send_sample(17'h15555, 17'h0AAAA, 17'h15555);
    send_sample(sample_t'(SAMPLE_LO), sample_t'(SAMPLE_HI), sample_t'(SAMPLE_LO));
  endtask

  // Zero noise first drives the gain to one, which clears the variance;
  // after that the denominator is zero and the estimates hold.
  task automatic test_zero_denominator();
    settle_idle();
    write_noise(CFG_Q, '0);
    write_noise(CFG_RXY, '0);
    write_noise(CFG_RZ, '0);
    send_sample(sample_t'(1000), sample_t'(-1000), sample_t'(5));
    send_sample(sample_t'(SAMPLE_HI), sample_t'(SAMPLE_LO), sample_t'(123));
    send_sample(sample_t'(-7), sample_t'(7), '0);
    send_sample(sample_t'(SAMPLE_LO), sample_t'(SAMPLE_HI), sample_t'(-1));
  endtask

  // Maximum process noise saturates the predicted variance.
  task automatic test_saturated_variance();
    settle_idle();
    write_noise(CFG_Q, NOISE_MAX);
    write_noise(CFG_RXY, NOISE_MAX);
    write_noise(CFG_RZ, 32'd1);
    send_sample(sample_t'(SAMPLE_HI), sample_t'(-300), sample_t'(SAMPLE_LO));
    send_sample(sample_t'(SAMPLE_LO), sample_t'(300), sample_t'(SAMPLE_HI));
    settle_idle();
    write_noise(CFG_RXY, '0);
    write_noise(CFG_RZ, NOISE_MAX);
    send_sample(sample_t'(12345), sample_t'(SAMPLE_LO), sample_t'(SAMPLE_HI));
    send_sample(sample_t'(-12345), sample_t'(SAMPLE_HI), sample_t'(SAMPLE_LO));
  endtask

  // A write to an index with no register must leave all noise values alone.
  task automatic test_spare_index();
    settle_idle();
    write_noise(CFG_Q, 32'h0000_8000);
    write_noise(CFG_SPARE, NOISE_MAX);
    send_sample(sample_t'(2000), sample_t'(-2000), sample_t'(40000));
    send_sample(sample_t'(2100), sample_t'(-1900), sample_t'(39000));
  endtask

  // Phases of random noise settings, each followed by a run of random items.
  task automatic test_random();
    int sent;
    int run;
    int level [3];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_idle();
      write_noise(CFG_Q, draw_noise());
      write_noise(CFG_RXY, draw_noise());
      write_noise(CFG_RZ, draw_noise());
      for (int a = 0; a < 3; a++) level[a] = int'($urandom_range(131071, 0)) + SAMPLE_LO;
      steady = ($urandom_range(3, 0) == 0);
      run = $urandom_range(160, 40);
      repeat (run) begin
        send_sample(draw_sample(level[0]), draw_sample(level[1]), draw_sample(level[2]));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: stalls a random number of cycles once a result is offered.
  initial begin : result_side
    est_set_t want;
    int stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(MAX_WAIT, 0);
      @(negedge clk_i);
      if (stall == 0) begin
        result_if.ready = 1'b1;
      end else begin
        result_if.ready = 1'b0;
        do @(posedge clk_i); while (!result_if.valid);
        repeat (stall) @(negedge clk_i);
        result_if.ready = 1'b1;
      end
      do @(posedge clk_i); while (!(result_if.valid && result_if.ready));
      if (estimates_due.size() == 0) begin
        $error("estimate item arrived with none expected");
        failed = 1'b1;
      end else begin
        want = estimates_due.pop_front();
        check_field("est_x", want.x, result_if.est_x);
        check_field("est_y", want.y, result_if.est_y);
        check_field("est_z", want.z, result_if.est_z);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : sequencer
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_Q;
    cfg_data_i = '0;
    sample_if.valid = 1'b0;
    sample_if.sample_x = '0;
    sample_if.sample_y = '0;
    sample_if.sample_z = '0;
    failed = 1'b0;
    steady = 1'b0;
    q_now = CFG_W'(32768);
    rxy_now = CFG_W'(NOISE_XY_UNITS) << FRAC;
    rz_now = CFG_W'(NOISE_Z_UNITS) << FRAC;
    for (int a = 0; a < 3; a++) begin
      estimate_now[a] = 0;
      variance_now[a] = '0;
    end
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_zero_denominator();
    test_saturated_variance();
    test_spare_index();
    test_random();

    // Drain, then allow one more latency for any stray result.
    while (estimates_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    if (!failed && estimates_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
